FILE: rtl/core/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
package ffha_pkg;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_RESIZE  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHECK,
		ST_AL_RD,
		ST_AL_WAIT,
		ST_AL_TEST,
		ST_AL_GROW,
		ST_RL_RD,
		ST_RL_WAIT,
		ST_RL_NEXT,
		ST_RL_NWAIT,
		ST_RL_TEST,
		ST_RZ_RD,
		ST_RZ_WAIT,
		ST_RZ_TEST,
		ST_RZ_WRD,
		ST_RZ_WWAIT,
		ST_RZ_WTEST,
		ST_RZ_FAIL,
		ST_DONE
	} ffha_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture the transaction
		logic rd_cursor;   // read header at cursor
		logic rd_home;     // read header at home block
		logic cur_zero;    // cursor to heap start
		logic cur_next;    // cursor to following header
		logic cur_home_next; // cursor past home block
		logic cur_home;    // cursor to home block
		logic al_take;     // mark cursor busy, result there
		logic al_grow;     // append block at top
		logic rl_clear;    // clear busy of home block
		logic rl_merge;    // absorb cursor block into home
		logic rz_inplace;  // keep offset, success
		logic rz_init;     // potential starts at zero
		logic rz_accum;    // add cursor block to potential
		logic rz_commit;   // write potential as home size, busy
		logic rz_restore;  // home busy again
		logic mv_begin;    // enlarge need for the move's alloc
		logic mv_done;     // report copy on success
		logic finish;      // present the result
	} ffha_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic req_zero;
		logic is_null;
		logic ptr_ok;
		logic cur_below_top;
		logic cur_busy;
		logic cur_fits;
		logic home_fits;
		logic pot_fits;
		logic alloc_ok;
	} ffha_stat_t;

endpackage

FILE: rtl/core/ffha_ctrl.sv
// controller state machine sequencing header walks
module ffha_ctrl import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_busy,
	input  ffha_stat_t st,
	output ffha_cmd_t  cmd,
	output logic       take
);

	ffha_state_t state_q, state_d;
	logic        moving_q, moving_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			moving_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			moving_q <= moving_d;
		end
	end

	assign take = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		state_d  = state_q;
		moving_d = moving_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				moving_d = 1'b0;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_DONE;
				if (st.command == CMD_ALLOC) begin
					if (!st.req_zero) state_d = ST_AL_RD;
				end else if (st.command == CMD_RELEASE) begin
					if (!st.is_null && st.ptr_ok) state_d = ST_RL_RD;
				end else if (st.command == CMD_RESIZE) begin
					if (st.req_zero) begin
						if (!st.is_null && st.ptr_ok) state_d = ST_RL_RD;
					end else if (st.is_null) begin
						state_d = ST_AL_RD;
					end else if (st.ptr_ok) begin
						state_d = ST_RZ_RD;
					end
				end
			end
			ST_AL_RD:   state_d = st.cur_below_top ? ST_AL_WAIT : ST_AL_GROW;
			ST_AL_WAIT: state_d = ST_AL_TEST;
			ST_AL_TEST: state_d = (!st.cur_busy && st.cur_fits) ?
				(moving_q ? ST_RL_RD : ST_DONE) : ST_AL_RD;
			ST_AL_GROW: state_d = (moving_q && st.alloc_ok) ? ST_RL_RD :
				(moving_q ? ST_RZ_FAIL : ST_DONE);
			ST_RL_RD:    state_d = ST_RL_WAIT;
			ST_RL_WAIT:  state_d = ST_RL_NEXT;
			ST_RL_NEXT:  state_d = st.cur_below_top ? ST_RL_NWAIT : ST_DONE;
			ST_RL_NWAIT: state_d = ST_RL_TEST;
			ST_RL_TEST:  state_d = st.cur_busy ? ST_DONE : ST_RL_RD;
			ST_RZ_RD:    state_d = ST_RZ_WAIT;
			ST_RZ_WAIT:  state_d = ST_RZ_TEST;
			ST_RZ_TEST:  state_d = st.home_fits ? ST_DONE : ST_RZ_WRD;
			ST_RZ_WRD:   state_d = st.cur_below_top ? ST_RZ_WWAIT : ST_AL_RD;
			ST_RZ_WWAIT: state_d = ST_RZ_WTEST;
			ST_RZ_WTEST: begin
				if (st.cur_busy) state_d = ST_AL_RD;
				else if (st.pot_fits) state_d = ST_DONE;
				else state_d = ST_RZ_WRD;
				if (st.cur_busy || (!st.cur_busy && !st.pot_fits)) moving_d = st.cur_busy;
			end
			ST_RZ_FAIL: state_d = ST_DONE;
			ST_DONE:    if (!out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
		// entering the move path
		if ((state_q == ST_RZ_WRD && !st.cur_below_top) ||
				(state_q == ST_RZ_WTEST && st.cur_busy))
			moving_d = 1'b1;
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_CHECK: begin
				if (st.command == CMD_RESIZE && !st.req_zero && !st.is_null && st.ptr_ok)
					cmd.cur_home = 1'b1;
				else
					cmd.cur_zero = 1'b1;
				if ((st.command == CMD_RELEASE || (st.command == CMD_RESIZE && st.req_zero))
						&& !st.is_null && st.ptr_ok)
					cmd.rl_clear = 1'b1;
			end
			ST_AL_RD:   begin
				cmd.rd_cursor = st.cur_below_top;
				cmd.al_grow   = !st.cur_below_top;
			end
			ST_AL_TEST: begin
				if (!st.cur_busy && st.cur_fits) begin
					cmd.al_take = 1'b1;
					if (moving_q) begin
						cmd.mv_done  = 1'b1;
						cmd.rl_clear = 1'b1;
					end
				end else begin
					cmd.cur_next = 1'b1;
				end
			end
			ST_AL_GROW: if (moving_q) begin
				if (st.alloc_ok) begin
					cmd.mv_done  = 1'b1;
					cmd.rl_clear = 1'b1;
				end
			end
			ST_RL_RD:    cmd.rd_home = 1'b1;
			ST_RL_WAIT:  cmd.cur_home_next = 1'b1;
			ST_RL_NEXT:  cmd.rd_cursor = st.cur_below_top;
			ST_RL_TEST:  cmd.rl_merge = !st.cur_busy;
			ST_RZ_RD:    cmd.rd_home = 1'b1;
			ST_RZ_TEST: begin
				cmd.rz_inplace = st.home_fits;
				cmd.rz_init    = 1'b1;
				cmd.rl_clear   = !st.home_fits;
			end
			ST_RZ_WRD: begin
				cmd.rd_cursor = st.cur_below_top;
				if (!st.cur_below_top) begin
					cmd.mv_begin = 1'b1;
					cmd.cur_zero = 1'b1;
				end
			end
			ST_RZ_WTEST: begin
				if (st.cur_busy) begin
					cmd.mv_begin = 1'b1;
					cmd.cur_zero = 1'b1;
				end else if (st.pot_fits) begin
					cmd.rz_commit = 1'b1;
				end else begin
					cmd.rz_accum = 1'b1;
					cmd.cur_next = 1'b1;
				end
			end
			ST_RZ_FAIL:  cmd.rz_restore = 1'b1;
			ST_DONE:     cmd.finish = 1'b1;
			default:     cmd = '0;
		endcase
	end

endmodule

FILE: rtl/core/ffha_dpath.sv
// datapath: header memories, cursor, potential sum and result registers
module ffha_dpath import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 524288,
	parameter int HEADER_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffha_cmd_t   cmd,
	input  logic        cfg_wr,
	input  logic [19:0] cfg_data,
	input  logic [1:0]  command,
	input  logic [19:0] request_bytes,
	input  logic [18:0] payload_offset,
	input  logic        pointer_is_null,
	output ffha_stat_t  st,
	output logic [18:0] result_offset,
	output logic        success,
	output logic [19:0] copy_bytes,
	output logic [18:0] copy_source
);

	localparam int SLOTS = HEAP_BYTES / 8;
	localparam int SW    = $clog2(SLOTS);
	localparam int AW    = 25; // wide enough for heap offsets up to the parameter range
	localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

	logic [19:0] size_mem [SLOTS];
	logic        busy_mem [SLOTS];

	logic [19:0] cap_q, top_q, req_q, old_size_q, home_size_q;
	logic [18:0] ptr_q;
	logic [1:0]  cmd_q;
	logic        null_q;
	logic [AW-1:0] cur_q, home_q, pot_q, need_q;
	logic [19:0] rd_size_q;
	logic        rd_busy_q;
	logic [18:0] res_off_q, res_src_q;
	logic        res_ok_q;
	logic [19:0] res_copy_q;

	// memory access: one read, one write address
	logic          rd_en, wr_en;
	logic [SW-1:0] rd_slot, wr_slot;
	logic [19:0]   wr_size;
	logic          wr_busy, wr_size_en;

	function automatic logic [SW-1:0] slot_of(input logic [AW-1:0] h);
		return h[SW+2:3];
	endfunction

	logic [AW-1:0] top_ext, limit, grow_end, cur_after, home_after;
	logic [AW-1:0] hdr_of_ptr;
	logic [AW-1:0] pot_sum;

	assign top_ext    = AW'(top_q);
	assign limit      = (AW'(cap_q) < AW'(HEAP_BYTES)) ? AW'(cap_q) : AW'(HEAP_BYTES);
	assign grow_end   = top_ext + need_q + HDR;
	assign cur_after  = cur_q + AW'(rd_size_q) + HDR;
	assign home_after = home_q + AW'(rd_size_q) + HDR;
	assign hdr_of_ptr = AW'(ptr_q) - HDR;
	assign pot_sum    = pot_q + AW'(rd_size_q) + HDR;

	always_comb begin
		rd_en      = cmd.rd_cursor || cmd.rd_home;
		rd_slot    = cmd.rd_home ? slot_of(home_q) : slot_of(cur_q);
		wr_en      = 1'b0;
		wr_size_en = 1'b0;
		wr_slot    = slot_of(home_q);
		wr_size    = home_size_q;
		wr_busy    = 1'b0;
		if (cmd.al_take) begin
			wr_en = 1'b1; wr_slot = slot_of(cur_q); wr_busy = 1'b1;
		end else if (cmd.al_grow && grow_end <= limit) begin
			wr_en = 1'b1; wr_size_en = 1'b1; wr_slot = slot_of(top_ext);
			wr_size = 20'(need_q); wr_busy = 1'b1;
		end else if (cmd.rl_clear) begin
			// home header follows from the pointer even before home_q is loaded
			wr_en = 1'b1; wr_slot = slot_of(hdr_of_ptr); wr_busy = 1'b0;
		end else if (cmd.rl_merge) begin
			wr_en = 1'b1; wr_size_en = 1'b1; wr_busy = 1'b0;
			wr_size = home_size_q + rd_size_q + 20'(HEADER_BYTES);
		end else if (cmd.rz_commit) begin
			wr_en = 1'b1; wr_size_en = 1'b1; wr_busy = 1'b1;
			wr_size = 20'(pot_sum - HDR);
		end else if (cmd.rz_restore) begin
			wr_en = 1'b1; wr_busy = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_size_q <= size_mem[rd_slot];
			rd_busy_q <= busy_mem[rd_slot];
		end
		if (wr_en) begin
			busy_mem[wr_slot] <= wr_busy;
			if (wr_size_en) size_mem[wr_slot] <= wr_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 20'd524288;
			top_q <= '0;
		end else begin
			if (cfg_wr) cap_q <= cfg_data;
			if (cmd.al_grow && grow_end <= limit) top_q <= 20'(grow_end);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			req_q    <= request_bytes;
			ptr_q    <= payload_offset;
			null_q   <= pointer_is_null;
			need_q   <= (AW'(request_bytes) + AW'(11)) & ~AW'(7);
			res_off_q <= '0; res_ok_q <= 1'b0; res_copy_q <= '0; res_src_q <= '0;
		end
		if (cmd.cur_zero) cur_q <= '0;
		if (cmd.cur_home) begin
			cur_q  <= hdr_of_ptr;
			need_q <= (AW'(req_q) + AW'(7)) & ~AW'(7);
		end
		// a move allocates with the header allowance on top of the rounded size
		if (cmd.mv_begin) need_q <= (need_q + AW'(11)) & ~AW'(7);
		if (cmd.rl_clear || cmd.cur_home) home_q <= hdr_of_ptr;
		if (cmd.cur_next) cur_q <= cur_after;
		if (cmd.cur_home_next) begin
			cur_q       <= home_after;
			home_size_q <= rd_size_q;
		end
		if (cmd.rl_merge) home_size_q <= home_size_q + rd_size_q + 20'(HEADER_BYTES);
		if (cmd.rz_init) begin
			pot_q       <= '0;
			old_size_q  <= rd_size_q;
		end
		if (cmd.rz_accum) pot_q <= pot_sum;
		if (cmd.al_take) begin
			res_ok_q  <= 1'b1;
			res_off_q <= 19'(cur_q + HDR);
		end
		if (cmd.al_grow && grow_end <= limit) begin
			res_ok_q  <= 1'b1;
			res_off_q <= 19'(top_ext + HDR);
		end
		if (cmd.rz_inplace || cmd.rz_commit) begin
			res_ok_q  <= 1'b1;
			res_off_q <= ptr_q;
		end
		if (cmd.mv_done) begin
			res_copy_q <= old_size_q;
			res_src_q  <= ptr_q;
		end
	end

	always_comb begin
		st.command       = cmd_q;
		st.req_zero      = (req_q == '0);
		st.is_null       = null_q;
		st.ptr_ok        = (AW'(ptr_q) >= HDR) && (hdr_of_ptr[2:0] == 3'd0)
			&& (hdr_of_ptr < top_ext);
		st.cur_below_top = cur_q < top_ext;
		st.cur_busy      = rd_busy_q;
		st.cur_fits      = AW'(rd_size_q) > need_q;
		st.home_fits     = need_q < AW'(rd_size_q);
		st.pot_fits      = (pot_sum > HDR) && (need_q < pot_sum - HDR);
		st.alloc_ok      = res_ok_q;
	end

	assign result_offset = res_off_q;
	assign success       = res_ok_q;
	assign copy_bytes    = res_copy_q;
	assign copy_source   = res_src_q;

endmodule

FILE: rtl/core/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
//  channel  | signals                                              | direction
//  request  | in_valid, in_stall, command, request_bytes,          | in
//           | payload_offset, pointer_is_null                      |
//  result   | out_valid, out_stall, result_offset, success,        | out
//           | copy_bytes, copy_source                              |
//  config   | cfg_we, cfg_wdata                                    | in
// one transaction at a time; allocate walks headers through the
// header memory (one read and one write port) plus decode,
// growth and result; release merges each free neighbor it reaches.
// resize walks its free neighbors; a move adds an allocate and a release.
// reset clears controller and heap top, sets capacity to 524288; header memory is not cleared.
// a stalled result holds the block in its result state until taken.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 524288,
	parameter int HEADER_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [19:0] request_bytes,
	input  logic [18:0] payload_offset,
	input  logic        pointer_is_null,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [18:0] result_offset,
	output logic        success,
	output logic [19:0] copy_bytes,
	output logic [18:0] copy_source,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata
);

	ffha_cmd_t  cmd;
	ffha_stat_t st;
	logic       take;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_busy(out_stall),
		.st(st), .cmd(cmd), .take(take)
	);

	ffha_dpath #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_wr(cfg_we), .cfg_data(cfg_wdata),
		.command(command), .request_bytes(request_bytes), .payload_offset(payload_offset),
		.pointer_is_null(pointer_is_null), .st(st), .result_offset(result_offset),
		.success(success), .copy_bytes(copy_bytes), .copy_source(copy_source)
	);

	assign in_stall  = !take;
	assign out_valid = cmd.finish;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && out_valid)) else $error("accept while result pending");
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> result_offset == '0 && copy_bytes == '0)
		else $error("failed result carries data");
	a_copy_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && copy_bytes != '0 |-> success) else $error("copy without success");

endmodule
